@@ src/cse_pkg.sv @@
// ----------------------------------------------------------------------------
// cse_pkg
// shared types and codes for the cbor scalar encoder
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam logic [2:0] OP_INT       = 3'd0;
    localparam logic [2:0] OP_TEXT_HDR  = 3'd1;
    localparam logic [2:0] OP_TEXT_BYTE = 3'd2;
    localparam logic [2:0] OP_BOOL      = 3'd3;
    localparam logic [2:0] OP_NULL      = 3'd4;

    localparam logic [7:0] HDR_UINT8    = 8'h18;
    localparam logic [7:0] HDR_UINT16   = 8'h19;
    localparam logic [7:0] HDR_UINT64   = 8'h1B;
    localparam logic [7:0] HDR_NINT64   = 8'h3B;
    localparam logic [7:0] HDR_TEXT     = 8'h60;
    localparam logic [7:0] HDR_TEXT8    = 8'h78;
    localparam logic [7:0] HDR_TEXT64   = 8'h7B;
    localparam logic [7:0] SIMPLE_TRUE  = 8'hF5;
    localparam logic [7:0] SIMPLE_FALSE = 8'hF4;
    localparam logic [7:0] SIMPLE_NULL  = 8'hF6;

    localparam int JOB_BYTES = 9;
    localparam int JOB_BITS  = 8 * JOB_BYTES;
    localparam int CNT_BITS  = 4;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [63:0] int_value;
        logic [31:0]        text_length;
        logic [7:0]         text_byte;
        logic               bool_value;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    // bytes left-aligned, first byte out in the top lane
    typedef struct packed {
        logic [JOB_BITS-1:0] bytes;
        logic [CNT_BITS-1:0] count;
    } job_t;

endpackage

@@ src/cbor_scalar_encoder.sv @@
// ----------------------------------------------------------------------------
// cbor_scalar_encoder
// encodes scalar items into a stream of cbor bytes, last byte marked
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item yields one
// to nine bytes on result, one per cycle with strobe high, and result.last set
// on its final byte; the receiver cannot stall. Single-byte items (text data,
// small integers, booleans, null) sustain one item per cycle; a longer item
// holds the byte serializer until its last byte is out, which sets the rate. A
// two-entry queue sits between the classifier and the serializer, and busy
// rises only while that queue is full. The first byte passes through the queue,
// the shift register and the result register. Unused opcodes give no bytes.
module cbor_scalar_encoder
    import cse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    strobe,
    output result_t result
);

    logic accept;
    logic push;
    logic pop;
    logic empty;
    logic full;
    job_t push_job;
    job_t head_job;

    assign busy   = full;
    assign accept = start && !full;

    cse_front u_front
    (
        .accept (accept),
        .cmd    (cmd),
        .push   (push),
        .job    (push_job)
    );

    cse_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    cse_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head_job (head_job),
        .pop      (pop),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

@@ src/cse_front.sv @@
// ----------------------------------------------------------------------------
// cse_front
// classifies an accepted item into a left-aligned byte string and length
// ----------------------------------------------------------------------------
module cse_front
    import cse_pkg::*;
(
    input  logic accept,
    input  cmd_t cmd,
    output logic push,
    output job_t job
);

    logic [63:0] iv;
    logic [31:0] len;

    assign iv  = cmd.int_value;
    assign len = cmd.text_length;

    always_comb
    begin
        push      = accept;
        job.bytes = '0;
        job.count = '0;
        case (cmd.opcode)
            OP_INT:
            begin
                if (iv[63])
                begin
                    job.bytes = {HDR_NINT64, ~iv};
                    job.count = CNT_BITS'(9);
                end
                else if (iv[63:5] == '0 && iv[4:0] <= 5'd23)
                begin
                    job.bytes = {iv[7:0], 64'd0};
                    job.count = CNT_BITS'(1);
                end
                else if (iv[63:8] == '0)
                begin
                    job.bytes = {HDR_UINT8, iv[7:0], 56'd0};
                    job.count = CNT_BITS'(2);
                end
                else if (iv[63:16] == '0)
                begin
                    job.bytes = {HDR_UINT16, iv[15:0], 48'd0};
                    job.count = CNT_BITS'(3);
                end
                else
                begin
                    job.bytes = {HDR_UINT64, iv};
                    job.count = CNT_BITS'(9);
                end
            end
            OP_TEXT_HDR:
            begin
                if (len[31:5] == '0 && len[4:0] <= 5'd23)
                begin
                    job.bytes = {HDR_TEXT | len[7:0], 64'd0};
                    job.count = CNT_BITS'(1);
                end
                else if (len[31:8] == '0)
                begin
                    job.bytes = {HDR_TEXT8, len[7:0], 56'd0};
                    job.count = CNT_BITS'(2);
                end
                else
                begin
                    job.bytes = {HDR_TEXT64, 32'd0, len};
                    job.count = CNT_BITS'(9);
                end
            end
            OP_TEXT_BYTE:
            begin
                job.bytes = {cmd.text_byte, 64'd0};
                job.count = CNT_BITS'(1);
            end
            OP_BOOL:
            begin
                job.bytes = {(cmd.bool_value ? SIMPLE_TRUE : SIMPLE_FALSE), 64'd0};
                job.count = CNT_BITS'(1);
            end
            OP_NULL:
            begin
                job.bytes = {SIMPLE_NULL, 64'd0};
                job.count = CNT_BITS'(1);
            end
            default:
            begin
                // unused opcode, item dropped
                push = 1'b0;
            end
        endcase
    end

endmodule

@@ src/cse_queue.sv @@
// ----------------------------------------------------------------------------
// cse_queue
// two-entry queue of classified jobs between front and back
// ----------------------------------------------------------------------------
module cse_queue
    import cse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic empty,
    output logic full
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign head_job = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ src/cse_back.sv @@
// ----------------------------------------------------------------------------
// cse_back
// shifts out one job byte per cycle into the registered result port
// ----------------------------------------------------------------------------
module cse_back
    import cse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    empty,
    input  job_t    head_job,
    output logic    pop,
    output logic    strobe,
    output result_t result
);

    logic [JOB_BITS-1:0] shift_reg;
    logic [JOB_BITS-1:0] shift_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                strobe_reg;
    logic                strobe_next;
    result_t             result_reg;
    result_t             result_next;

    // take the next job when idle or on the last byte of the current one
    assign pop = !empty && (cnt_reg <= CNT_BITS'(1));

    always_comb
    begin
        strobe_next          = (cnt_reg != '0);
        result_next.out_byte = shift_reg[JOB_BITS-1 -: 8];
        result_next.last     = (cnt_reg == CNT_BITS'(1));
        if (pop)
        begin
            shift_next = head_job.bytes;
            cnt_next   = head_job.count;
        end
        else if (cnt_reg != '0)
        begin
            shift_next = {shift_reg[JOB_BITS-9:0], 8'd0};
            cnt_next   = cnt_reg - CNT_BITS'(1);
        end
        else
        begin
            shift_next = shift_reg;
            cnt_next   = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg  <= shift_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the cbor scalar encoder
// ----------------------------------------------------------------------------
// Drives integers, text headers, text bytes, booleans, null and unused
// opcodes through the command port in random bursts. A scoreboard computes
// the cbor byte stream of every accepted item and checks each strobed byte
// and its last flag in order.
// ----------------------------------------------------------------------------
module tb_top;
    import cse_pkg::*;

    localparam logic [2:0]  OP_RSVD5   = 3'd5;
    localparam logic [2:0]  OP_RSVD6   = 3'd6;
    localparam logic [2:0]  OP_RSVD7   = 3'd7;
    localparam logic [63:0] IMM_MAX    = 64'd23;
    localparam logic [63:0] U8_MAX     = 64'd255;
    localparam logic [63:0] U16_MAX    = 64'd65535;
    localparam int          TARGET     = 180;
    localparam int          DRAIN_WAIT = 5000;

    class cbor_scoreboard;
        result_t byte_q[$];
        int      n_err;
        int      n_bytes;
        int      n_int, n_hdr, n_txt, n_simple, n_rsvd;

        function void push_head(logic [7:0] head, logic [63:0] val, int n);
            result_t r;
            r.out_byte = head;
            r.last     = (n == 0);
            byte_q.push_back(r);
            for (int i = 0; i < n; i++)
            begin
                r.out_byte = val[8*(n-1-i) +: 8];
                r.last     = (i == n - 1);
                byte_q.push_back(r);
            end
        endfunction

        function void note_item(cmd_t c);
            logic [63:0] v;
            logic [63:0] len;
            v   = c.int_value;
            len = {32'd0, c.text_length};
            case (c.opcode)
                OP_INT:
                begin
                    n_int++;
                    if (v[63])
                        push_head(HDR_NINT64, ~v, 8);
                    else if (v <= IMM_MAX)
                        push_head(v[7:0], '0, 0);
                    else if (v <= U8_MAX)
                        push_head(HDR_UINT8, v, 1);
                    else if (v <= U16_MAX)
                        push_head(HDR_UINT16, v, 2);
                    else
                        push_head(HDR_UINT64, v, 8);
                end
                OP_TEXT_HDR:
                begin
                    n_hdr++;
                    if (len <= IMM_MAX)
                        push_head(HDR_TEXT | len[7:0], '0, 0);
                    else if (len <= U8_MAX)
                        push_head(HDR_TEXT8, len, 1);
                    else
                        push_head(HDR_TEXT64, len, 8);
                end
                OP_TEXT_BYTE:
                begin
                    n_txt++;
                    push_head(c.text_byte, '0, 0);
                end
                OP_BOOL:
                begin
                    n_simple++;
                    push_head(c.bool_value ? SIMPLE_TRUE : SIMPLE_FALSE, '0, 0);
                end
                OP_NULL:
                begin
                    n_simple++;
                    push_head(SIMPLE_NULL, '0, 0);
                end
                default:
                    n_rsvd++;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            n_bytes++;
            if (byte_q.size() == 0)
            begin
                n_err++;
                $display("%0t: unexpected byte %02h last %0b", $time, got.out_byte, got.last);
                return;
            end
            want = byte_q.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                n_err++;
                $display("%0t: out_byte expected %02h actual %02h",
                         $time, want.out_byte, got.out_byte);
            end
            if (got.last !== want.last)
            begin
                n_err++;
                $display("%0t: last expected %0b actual %0b (byte %02h)",
                         $time, want.last, got.last, want.out_byte);
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    strobe;
    result_t result;

    cbor_scoreboard sb;
    int             burst_left;
    int             n_valid;

    cbor_scalar_encoder u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #2ms;
        $display("tb_top: timeout");
        $display("tb_top: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_item(cmd);
        if (rst_n && strobe)
            sb.check_result(result);
    end

    function automatic cmd_t make_cmd(logic [2:0] op, logic [63:0] iv, logic [31:0] len,
                                      logic [7:0] tbyte, logic bv);
        cmd_t c;
        c.opcode      = op;
        c.int_value   = iv;
        c.text_length = len;
        c.text_byte   = tbyte;
        c.bool_value  = bv;
        return c;
    endfunction

    function automatic cmd_t noise_cmd(logic [2:0] op);
        return make_cmd(op, {$urandom, $urandom}, $urandom, 8'($urandom), 1'($urandom));
    endfunction

    task automatic issue(cmd_t c);
        int gap;
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        if (c.opcode <= OP_NULL)
            n_valid++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic [63:0] rand_int();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0: v = 64'($urandom_range(0, 23));
            1: v = 64'($urandom_range(24, 255));
            2: v = 64'($urandom_range(256, 65535));
            3:
            begin
                v[63] = 1'b0;
                v = (v >> $urandom_range(0, 46)) | 64'h1_0000;
            end
            4: ;
            5: v = -64'sd1 - 64'($urandom_range(0, 300));
            default:
            begin
                case ($urandom_range(0, 7))
                    0: v = 64'd23;
                    1: v = 64'd24;
                    2: v = 64'd255;
                    3: v = 64'd256;
                    4: v = 64'd65535;
                    5: v = 64'd65536;
                    6: v = 64'h7FFF_FFFF_FFFF_FFFF;
                    default: v = 64'h8000_0000_0000_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 5))
            0, 1: return $urandom_range(0, 23);
            2: return $urandom_range(24, 255);
            3: return $urandom_range(256, 65535);
            4: return $urandom;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'd23;
                    1: return 32'd24;
                    2: return 32'd255;
                    3: return 32'd256;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    task automatic run_directed();
        issue(make_cmd(OP_INT, 64'd0, $urandom, 8'($urandom), 1'($urandom)));
        issue(make_cmd(OP_INT, 64'd23, $urandom, 8'($urandom), 1'($urandom)));
        issue(make_cmd(OP_INT, 64'd24, $urandom, 8'($urandom), 1'($urandom)));
        issue(make_cmd(OP_INT, 64'd255, $urandom, 8'($urandom), 1'($urandom)));
        issue(make_cmd(OP_INT, 64'd256, $urandom, 8'($urandom), 1'($urandom)));
        issue(make_cmd(OP_INT, 64'd65535, $urandom, 8'($urandom), 1'($urandom)));
        issue(make_cmd(OP_INT, 64'd65536, $urandom, 8'($urandom), 1'($urandom)));
        issue(make_cmd(OP_INT, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, '0));
        issue(make_cmd(OP_INT, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0));
        issue(make_cmd(OP_INT, 64'h8000_0000_0000_0000, '1, '1, 1'b1));
        issue(make_cmd(OP_TEXT_HDR, {$urandom, $urandom}, 32'd0, 8'($urandom),
                       1'($urandom)));
        issue(make_cmd(OP_TEXT_HDR, '0, 32'd23, '0, '0));
        issue(make_cmd(OP_TEXT_HDR, '0, 32'd24, '0, '0));
        issue(make_cmd(OP_TEXT_HDR, '1, 32'd255, '1, 1'b1));
        issue(make_cmd(OP_TEXT_HDR, '0, 32'd256, '0, '0));
        issue(make_cmd(OP_TEXT_HDR, '0, 32'hFFFF_FFFF, '0, '0));
        issue(make_cmd(OP_TEXT_BYTE, '1, '1, 8'h00, 1'b1));
        issue(make_cmd(OP_TEXT_BYTE, '0, '0, 8'hFF, 1'b0));
        issue(make_cmd(OP_BOOL, '0, '0, '0, 1'b0));
        issue(make_cmd(OP_BOOL, '1, '1, '1, 1'b1));
        issue(make_cmd(OP_NULL, {$urandom, $urandom}, $urandom, 8'($urandom),
                       1'($urandom)));
        // unused opcodes give nothing
        issue(noise_cmd(OP_RSVD5));
        issue(noise_cmd(OP_RSVD6));
        issue(noise_cmd(OP_RSVD7));
        issue(make_cmd(OP_NULL, '1, '1, '1, 1'b1));
    endtask

    task automatic run_random();
        cmd_t c;
        int   len;
        while (n_valid < TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    // header plus its string bytes
                    len = $urandom_range(0, 30);
                    issue(make_cmd(OP_TEXT_HDR, {$urandom, $urandom}, 32'(len),
                                   8'($urandom), 1'($urandom)));
                    repeat (len) issue(noise_cmd(OP_TEXT_BYTE));
                end
                3, 4, 5:
                begin
                    c = noise_cmd(OP_INT);
                    c.int_value = rand_int();
                    issue(c);
                end
                6:
                begin
                    c = noise_cmd(OP_TEXT_HDR);
                    c.text_length = rand_len();
                    issue(c);
                end
                7: issue(noise_cmd(($urandom_range(0, 2) == 0) ? OP_NULL : OP_BOOL));
                8: issue(noise_cmd(OP_TEXT_BYTE));
                default: issue(noise_cmd(3'($urandom_range(5, 7))));
            endcase
        end
    endtask

    initial
    begin
        int waited;
        sb         = new();
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        burst_left = 1;
        n_valid    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();
        start <= 1'b0;

        waited = 0;
        while (sb.byte_q.size() != 0 && waited < DRAIN_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (sb.byte_q.size() != 0)
        begin
            sb.n_err++;
            $display("%0t: %0d bytes never arrived", $time, sb.byte_q.size());
        end

        $display("run: %0d integers, %0d text headers, %0d text bytes, %0d simple values,",
                 sb.n_int, sb.n_hdr, sb.n_txt, sb.n_simple);
        $display("     %0d ignored opcodes, %0d output bytes checked, %0d errors",
                 sb.n_rsvd, sb.n_bytes, sb.n_err);
        if (sb.n_err == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
